[src/kgq_pkg.sv]
// ----------------------------------------------------------------------------
// kgq_pkg
// Shared types and codes for the keypoint grid bucket and window query block.
// ----------------------------------------------------------------------------
package kgq_pkg;

	localparam int FRAC_BITS = 20;
	localparam int CW        = 15;	// signed width of a cell coordinate
	localparam int OPW       = 18;	// signed width of a shifted position
	localparam int PW        = 35;	// signed width of a cell product

	typedef enum logic [1:0] {
		MODE_CLR = 2'd0,
		MODE_INS = 2'd1,
		MODE_QRY = 2'd2,
		MODE_NOP = 2'd3
	} kgq_mode_t;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_OUT   = 2'd1,
		STAT_FULL  = 2'd2,
		STAT_TRUNC = 2'd3
	} kgq_status_t;

	typedef enum logic [1:0] {
		REG_ORIGIN_X = 2'd0,
		REG_ORIGIN_Y = 2'd1,
		REG_INV_W    = 2'd2,
		REG_INV_H    = 2'd3
	} kgq_reg_t;

	typedef enum logic [3:0] {
		ST_CLR,
		ST_IDLE,
		ST_MUL,
		ST_CNV,
		ST_INS_CHK,
		ST_INS_WR,
		ST_Q_CHK,
		ST_Q_CELL,
		ST_Q_FILL,
		ST_Q_SCAN,
		ST_Q_ENT,
		ST_Q_PT,
		ST_EMIT
	} kgq_state_t;

endpackage

[src/kgq_if.sv]
// ----------------------------------------------------------------------------
// kgq_if
// Valid/ready channels for keypoint items and result beats.
// ----------------------------------------------------------------------------
interface kgq_in_if;
	logic               valid;
	logic               ready;
	logic [1:0]         mode;
	logic signed [15:0] pos_x;
	logic signed [15:0] pos_y;
	logic [2:0]         octave;
	logic [14:0]        radius;
	logic [2:0]         min_level;
	logic signed [3:0]  max_level;

	modport source (output valid, mode, pos_x, pos_y, octave, radius, min_level, max_level,
		input ready);
	modport sink (input valid, mode, pos_x, pos_y, octave, radius, min_level, max_level,
		output ready);
endinterface

interface kgq_out_if;
	logic       valid;
	logic       ready;
	logic [9:0] feature_index;
	logic       hit_valid;
	logic       last;
	logic [1:0] status;

	modport source (output valid, feature_index, hit_valid, last, status, input ready);
	modport sink (input valid, feature_index, hit_valid, last, status, output ready);
endinterface

[src/keypoint_grid_bucket_and_window_query.sv]
// ----------------------------------------------------------------------------
// keypoint_grid_bucket_and_window_query
// Keypoint table plus uniform grid of cell buckets, with window queries.
//
// channel   dir  handshake        beat
// in_ch     in   valid/ready      mode, pos_x, pos_y, octave, radius, levels
// out_ch    out  valid/ready      feature_index, hit_valid, last, status
// apb       in   psel/penable     16-bit origin and inverse cell size regs
//
// Insert: multiply/convert steps for column and row, fill read, write, then
// the result beat. Query: multiply/convert steps for the four window bounds,
// window check, then per cell a fill read and scan, per bucket entry an entry
// read and point test, and the closing beat; the walk over the fill, entry
// and point memories sets the rate. Clear and reset sweep the fill memory
// with in_ch.ready low. A full output register stalls the walk.
// ----------------------------------------------------------------------------
module keypoint_grid_bucket_and_window_query
	import kgq_pkg::*;
#(
	parameter int GRID_COLS    = 64,
	parameter int GRID_ROWS    = 48,
	parameter int MAX_POINTS   = 1024,
	parameter int BUCKET_DEPTH = 16,
	parameter int MAX_HITS     = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	kgq_in_if.sink      in_ch,
	kgq_out_if.source   out_ch,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int CELLS = GRID_COLS * GRID_ROWS;
	localparam int CELLW = (CELLS > 1) ? $clog2(CELLS) : 1;
	localparam int ENTS  = CELLS * BUCKET_DEPTH;
	localparam int EW    = (ENTS > 1) ? $clog2(ENTS) : 1;
	localparam int IW    = $clog2(MAX_POINTS);
	localparam int CIW   = (GRID_COLS > 1) ? $clog2(GRID_COLS) : 1;
	localparam int RIW   = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1;
	localparam int FW    = $clog2(BUCKET_DEPTH + 1);
	localparam int NW    = $clog2(MAX_HITS + 1);
	localparam logic signed [CW-1:0] COLS_S = CW'(GRID_COLS);
	localparam logic signed [CW-1:0] ROWS_S = CW'(GRID_ROWS);

	// configuration
	logic signed [15:0] origin_x_q, origin_y_q;
	logic [15:0]        inv_w_q, inv_h_q;
	logic               cfg_we;

	assign pready = 1'b1;
	assign cfg_we = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q <= '0;
			origin_y_q <= '0;
			inv_w_q    <= 16'd6554;
			inv_h_q    <= 16'd6554;
		end else if (cfg_we) begin
			unique case (kgq_reg_t'(paddr[3:2]))
				REG_ORIGIN_X: origin_x_q <= pwdata[15:0];
				REG_ORIGIN_Y: origin_y_q <= pwdata[15:0];
				REG_INV_W:    inv_w_q    <= pwdata[15:0];
				REG_INV_H:    inv_h_q    <= pwdata[15:0];
				default:      ;
			endcase
		end
	end

	always_comb begin
		unique case (kgq_reg_t'(paddr[3:2]))
			REG_ORIGIN_X: prdata = {16'd0, origin_x_q};
			REG_ORIGIN_Y: prdata = {16'd0, origin_y_q};
			REG_INV_W:    prdata = {16'd0, inv_w_q};
			REG_INV_H:    prdata = {16'd0, inv_h_q};
			default:      prdata = '0;
		endcase
	end

	// control and item registers
	kgq_state_t state_q, state_d;
	logic [1:0]         mode_q;
	logic signed [15:0] x_q, y_q;
	logic [2:0]         minl_q;
	logic [14:0]        r_q;
	logic signed [3:0]  maxl_q;
	logic [1:0]         step_q;
	logic signed [PW-1:0] prod_q;
	logic signed [CW-1:0] bnd_q [4];
	logic [IW:0]        cnt_q;
	logic [IW-1:0]      idx_q;
	logic [CELLW-1:0]   clr_cnt_q, cell_q;
	logic               clr_item_q;
	logic [CIW-1:0]     ci_q, c1_q;
	logic [RIW-1:0]     ri_q, r0_q, r1_q;
	logic [FW-1:0]      fill_q, j_q;
	logic [NW-1:0]      n_q;
	logic [IW-1:0]      held_q;
	logic               held_vld_q;
	logic [IW-1:0]      res_idx_q;
	logic               res_vld_q;
	logic [1:0]         res_st_q;

	// output register
	logic       out_vld_q, out_hit_q, out_last_q, ld_out, out_free;
	logic [9:0] out_idx_q;
	logic [1:0] out_st_q;

	assign out_free      = !out_vld_q || out_ch.ready;
	assign out_ch.valid         = out_vld_q;
	assign out_ch.feature_index = out_idx_q;
	assign out_ch.hit_valid     = out_hit_q;
	assign out_ch.last          = out_last_q;
	assign out_ch.status        = out_st_q;

	logic in_acc;
	assign in_ch.ready = (state_q == ST_IDLE);
	assign in_acc      = in_ch.valid & in_ch.ready;

	// memories
	logic [34:0]      pt_mem [MAX_POINTS];
	logic [FW-1:0]    fill_mem [CELLS];
	logic [IW-1:0]    ent_mem [ENTS];
	logic [34:0]      pt_rd;
	logic [FW-1:0]    fill_rd;
	logic [IW-1:0]    ent_rd;
	logic             pt_we, pt_re, fill_we, fill_re, ent_we, ent_re;
	logic [CELLW-1:0] fill_wa, fill_ra;
	logic [FW-1:0]    fill_wd;
	logic [EW-1:0]    ent_wa, ent_ra;

	always_ff @(posedge clk) begin
		if (pt_we)
			pt_mem[cnt_q[IW-1:0]] <= {in_ch.pos_x, in_ch.pos_y, in_ch.octave};
		if (pt_re)
			pt_rd <= pt_mem[ent_rd];
	end

	always_ff @(posedge clk) begin
		if (fill_we)
			fill_mem[fill_wa] <= fill_wd;
		if (fill_re)
			fill_rd <= fill_mem[fill_ra];
	end

	always_ff @(posedge clk) begin
		if (ent_we)
			ent_mem[ent_wa] <= idx_q;
		if (ent_re)
			ent_rd <= ent_mem[ent_ra];
	end

	// cell coordinate datapath: one shared multiplier, one step per pass
	logic                  dim_y, is_qry, last_step;
	logic signed [OPW-1:0] opnd, rad_s;
	logic signed [PW-1:0]  ceil_sum, mag, rmag;
	logic signed [CW-1:0]  conv;

	assign is_qry    = (mode_q == MODE_QRY);
	assign dim_y     = is_qry ? step_q[1] : step_q[0];
	assign rad_s     = is_qry ? OPW'({3'd0, r_q}) : '0;
	assign last_step = is_qry ? (step_q == 2'd3) : (step_q == 2'd1);

	always_comb begin
		opnd = dim_y ? (OPW'(y_q) - OPW'(origin_y_q)) : (OPW'(x_q) - OPW'(origin_x_q));
		opnd = step_q[0] ? (opnd + rad_s) : (opnd - rad_s);
		ceil_sum = prod_q + PW'((1 << FRAC_BITS) - 1);
		mag      = prod_q[PW-1] ? -prod_q : prod_q;
		rmag     = mag + PW'(1 << (FRAC_BITS - 1));
		if (!is_qry)
			conv = prod_q[PW-1] ? -rmag[PW-1:FRAC_BITS] : rmag[PW-1:FRAC_BITS];
		else if (step_q[0])
			conv = ceil_sum[PW-1:FRAC_BITS];
		else
			conv = prod_q[PW-1:FRAC_BITS];
	end

	// insert cell
	logic             ins_out, fill_full;
	logic [CELLW-1:0] ins_cell, q_cell;

	assign ins_out   = bnd_q[0] < 0 || bnd_q[0] >= COLS_S || bnd_q[1] < 0 || bnd_q[1] >= ROWS_S;
	assign ins_cell  = CELLW'(bnd_q[0][CIW-1:0] * GRID_ROWS + bnd_q[1][RIW-1:0]);
	assign q_cell    = CELLW'(ci_q * GRID_ROWS + ri_q);
	assign fill_full = fill_rd >= FW'(BUCKET_DEPTH);

	// query window
	logic             q_empty;
	logic [CIW-1:0]   c0c, c1c;
	logic [RIW-1:0]   r0c, r1c;

	assign q_empty = bnd_q[0] >= COLS_S || bnd_q[1] < 0 || bnd_q[2] >= ROWS_S || bnd_q[3] < 0;
	assign c0c = (bnd_q[0] < 0) ? '0 : bnd_q[0][CIW-1:0];
	assign c1c = (bnd_q[1] > COLS_S - 1) ? CIW'(GRID_COLS - 1) : bnd_q[1][CIW-1:0];
	assign r0c = (bnd_q[2] < 0) ? '0 : bnd_q[2][RIW-1:0];
	assign r1c = (bnd_q[3] > ROWS_S - 1) ? RIW'(GRID_ROWS - 1) : bnd_q[3][RIW-1:0];

	// candidate test
	logic signed [16:0] dx, dy;
	logic [16:0]        adx, ady;
	logic [2:0]         lv;
	logic               lvl_ok, match, scan_end, trunc;

	assign lv     = pt_rd[2:0];
	assign dx     = 17'(signed'(pt_rd[34:19])) - 17'(x_q);
	assign dy     = 17'(signed'(pt_rd[18:3])) - 17'(y_q);
	assign adx    = dx[16] ? 17'(-dx) : 17'(dx);
	assign ady    = dy[16] ? 17'(-dy) : 17'(dy);
	assign lvl_ok = (lv >= minl_q) && (maxl_q[3] || lv <= maxl_q[2:0]);
	assign match  = lvl_ok && adx < {2'd0, r_q} && ady < {2'd0, r_q};
	assign scan_end = (j_q == fill_q);
	assign trunc    = (n_q == NW'(MAX_HITS));

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLR:
				if (clr_cnt_q == CELLW'(CELLS - 1))
					state_d = clr_item_q ? ST_EMIT : ST_IDLE;
			ST_IDLE:
				if (in_acc) begin
					unique case (kgq_mode_t'(in_ch.mode))
						MODE_CLR: state_d = ST_CLR;
						MODE_INS: state_d = (cnt_q >= (IW+1)'(MAX_POINTS)) ? ST_EMIT : ST_MUL;
						MODE_QRY: state_d = ST_MUL;
						default:  state_d = ST_IDLE;
					endcase
				end
			ST_MUL:     state_d = ST_CNV;
			ST_CNV:
				if (last_step)
					state_d = is_qry ? ST_Q_CHK : ST_INS_CHK;
				else
					state_d = ST_MUL;
			ST_INS_CHK: state_d = ins_out ? ST_EMIT : ST_INS_WR;
			ST_INS_WR:  state_d = ST_EMIT;
			ST_Q_CHK:   state_d = q_empty ? ST_EMIT : ST_Q_CELL;
			ST_Q_CELL:  state_d = ST_Q_FILL;
			ST_Q_FILL:  state_d = ST_Q_SCAN;
			ST_Q_SCAN:
				if (!scan_end)
					state_d = ST_Q_ENT;
				else if (ri_q == r1_q && ci_q == c1_q)
					state_d = ST_EMIT;
				else
					state_d = ST_Q_CELL;
			ST_Q_ENT:   state_d = ST_Q_PT;
			ST_Q_PT:
				if (match && trunc)
					state_d = ST_EMIT;
				else if (!(match && held_vld_q && !out_free))
					state_d = ST_Q_SCAN;
			ST_EMIT:
				if (out_free)
					state_d = ST_IDLE;
			default:    state_d = ST_IDLE;
		endcase
	end

	// memory ports and output load
	always_comb begin
		pt_we   = (state_q == ST_IDLE) && in_acc && in_ch.mode == MODE_INS &&
			cnt_q < (IW+1)'(MAX_POINTS);
		pt_re   = (state_q == ST_Q_ENT);
		fill_re = (state_q == ST_INS_CHK) || (state_q == ST_Q_CELL);
		fill_ra = (state_q == ST_INS_CHK) ? ins_cell : q_cell;
		fill_we = (state_q == ST_CLR) || (state_q == ST_INS_WR && !fill_full);
		fill_wa = (state_q == ST_CLR) ? clr_cnt_q : cell_q;
		fill_wd = (state_q == ST_CLR) ? '0 : fill_rd + FW'(1);
		ent_we  = (state_q == ST_INS_WR) && !fill_full;
		ent_wa  = EW'(cell_q * BUCKET_DEPTH + fill_rd);
		ent_re  = (state_q == ST_Q_SCAN) && !scan_end;
		ent_ra  = EW'(cell_q * BUCKET_DEPTH + j_q);
		ld_out  = ((state_q == ST_EMIT) && out_free) ||
			((state_q == ST_Q_PT) && match && !trunc && held_vld_q && out_free);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLR;
			clr_cnt_q  <= '0;
			clr_item_q <= 1'b0;
			cnt_q      <= '0;
			held_vld_q <= 1'b0;
			n_q        <= '0;
			out_vld_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLR)
				clr_cnt_q <= clr_cnt_q + CELLW'(1);
			if (in_acc && in_ch.mode == MODE_CLR) begin
				clr_cnt_q  <= '0;
				clr_item_q <= 1'b1;
				cnt_q      <= '0;
			end
			if (pt_we)
				cnt_q <= cnt_q + (IW+1)'(1);
			if (state_q == ST_Q_CHK) begin
				held_vld_q <= 1'b0;
				n_q        <= '0;
			end
			if (state_q == ST_Q_PT && match && !trunc && (!held_vld_q || out_free)) begin
				held_vld_q <= 1'b1;
				n_q        <= n_q + NW'(1);
			end
			if (ld_out)
				out_vld_q <= 1'b1;
			else if (out_ch.ready)
				out_vld_q <= 1'b0;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			mode_q <= in_ch.mode;
			x_q    <= in_ch.pos_x;
			y_q    <= in_ch.pos_y;
			r_q    <= in_ch.radius;
			minl_q <= in_ch.min_level;
			maxl_q <= in_ch.max_level;
			step_q <= '0;
			idx_q  <= cnt_q[IW-1:0];
			// clear result and table-full result
			res_idx_q <= '0;
			res_vld_q <= 1'b0;
			res_st_q  <= (in_ch.mode == MODE_INS) ? STAT_FULL : STAT_OK;
		end
		if (state_q == ST_MUL)
			prod_q <= opnd * PW'(signed'({1'b0, dim_y ? inv_h_q : inv_w_q}));
		if (state_q == ST_CNV) begin
			bnd_q[step_q] <= conv;
			step_q        <= step_q + 2'd1;
		end
		if (state_q == ST_INS_CHK) begin
			cell_q    <= ins_cell;
			res_idx_q <= idx_q;
			res_vld_q <= 1'b1;
			res_st_q  <= ins_out ? STAT_OUT : STAT_OK;
		end
		if (state_q == ST_INS_WR && fill_full)
			res_st_q <= STAT_FULL;
		if (state_q == ST_Q_CHK) begin
			ci_q      <= c0c;
			c1_q      <= c1c;
			ri_q      <= r0c;
			r0_q      <= r0c;
			r1_q      <= r1c;
			res_idx_q <= '0;
			res_vld_q <= 1'b0;
			res_st_q  <= STAT_OK;
		end
		if (state_q == ST_Q_CELL)
			cell_q <= q_cell;
		if (state_q == ST_Q_FILL) begin
			fill_q <= fill_full ? FW'(BUCKET_DEPTH) : fill_rd;
			j_q    <= '0;
		end
		if (state_q == ST_Q_SCAN && scan_end) begin
			if (ri_q == r1_q) begin
				ri_q <= r0_q;
				ci_q <= ci_q + CIW'(1);
			end else begin
				ri_q <= ri_q + RIW'(1);
			end
			// the held hit, if any, closes the item
			if (held_vld_q) begin
				res_idx_q <= held_q;
				res_vld_q <= 1'b1;
			end
		end
		if (state_q == ST_Q_PT) begin
			if (match && trunc) begin
				res_idx_q <= held_q;
				res_vld_q <= 1'b1;
				res_st_q  <= STAT_TRUNC;
			end else if (!match) begin
				j_q <= j_q + FW'(1);
			end else if (!held_vld_q || out_free) begin
				held_q <= ent_rd;
				j_q    <= j_q + FW'(1);
			end
		end
		if (ld_out) begin
			if (state_q == ST_EMIT) begin
				out_idx_q  <= 10'(res_idx_q);
				out_hit_q  <= res_vld_q;
				out_last_q <= 1'b1;
				out_st_q   <= res_st_q;
			end else begin
				out_idx_q  <= 10'(held_q);
				out_hit_q  <= 1'b1;
				out_last_q <= 1'b0;
				out_st_q   <= STAT_OK;
			end
		end
	end

	// checks
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (IW+1)'(MAX_POINTS))
		else $error("feature count past table size");

	a_hits_bound: assert property (@(posedge clk) disable iff (!arst_n)
		n_q <= NW'(MAX_HITS))
		else $error("hit count past limit");

	a_ins_count: assert property (@(posedge clk) disable iff (!arst_n)
		pt_we |=> cnt_q == $past(cnt_q) + (IW+1)'(1))
		else $error("insert did not advance feature count");

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLR) |-> !in_ch.ready)
		else $error("item taken during fill sweep");

endmodule

[test/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the keypoint grid bucket and window query block.
// Items go in over a valid/ready channel with random gaps. Result beats come
// out under random backpressure. A scoreboard keeps its own copy of the
// keypoint table, the cell buckets and the registers, predicts the beats of
// every accepted item and compares them in order. Register settings change
// between phases while the block is idle. The closing phase packs keypoints
// into a few cells to reach full buckets and truncated queries.
// ----------------------------------------------------------------------------
module tb;
	import kgq_pkg::*;

	localparam int COLS   = 64;
	localparam int ROWS   = 48;
	localparam int NPTS   = 1024;
	localparam int DEPTH  = 16;
	localparam int NHITS  = 64;
	localparam int FRAC   = 20;

	typedef struct {
		kgq_mode_t          mode;
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic [2:0]         oct;
		logic [14:0]        rad;
		logic [2:0]         minl;
		logic signed [3:0]  maxl;
	} kp_item_t;

	typedef struct {
		logic [9:0]  idx;
		logic        hit;
		logic        last;
		kgq_status_t status;
	} kp_beat_t;

	class grid_scoreboard;
		logic signed [15:0] pt_x[NPTS];
		logic signed [15:0] pt_y[NPTS];
		logic [2:0]         pt_lvl[NPTS];
		int                 npoints;
		int                 fill[COLS*ROWS];
		int                 bucket[COLS*ROWS*DEPTH];
		logic signed [15:0] org_x, org_y;
		logic [15:0]        inv_w, inv_h;
		kp_beat_t           pending_beats[$];
		int                 errors;

		function new();
			npoints = 0;
			foreach (fill[i]) fill[i] = 0;
			org_x = 0;
			org_y = 0;
			inv_w = 16'd6554;
			inv_h = 16'd6554;
			errors = 0;
		endfunction

		function void set_reg(kgq_reg_t r, logic [15:0] v);
			case (r)
				REG_ORIGIN_X: org_x = v;
				REG_ORIGIN_Y: org_y = v;
				REG_INV_W:    inv_w = v;
				default:      inv_h = v;
			endcase
		endfunction

		function longint fl(longint v);
			return v >>> FRAC;
		endfunction

		function longint rnd(longint v);
			longint m;
			m = (v < 0) ? -v : v;
			m = (m + (longint'(1) << (FRAC - 1))) >>> FRAC;
			return (v < 0) ? -m : m;
		endfunction

		function void push(logic [9:0] i, logic h, logic l, kgq_status_t s);
			kp_beat_t b;
			b.idx = i;
			b.hit = h;
			b.last = l;
			b.status = s;
			pending_beats.insert(pending_beats.size(), b);
		endfunction

		// work out the beats of one accepted item and update the model state
		function void note_item(kp_item_t it);
			longint x, y, ox, oy, iw, ih, r, cx, cy, c0, c1, r0, r1, dx, dy;
			int cidx, n, id, first;
			bit chk, trunc;
			x = it.x;
			y = it.y;
			ox = org_x;
			oy = org_y;
			iw = inv_w;
			ih = inv_h;
			r = it.rad;
			case (it.mode)
				MODE_CLR: begin
					npoints = 0;
					foreach (fill[i]) fill[i] = 0;
					push('0, 1'b0, 1'b1, STAT_OK);
				end
				MODE_INS: begin
					if (npoints >= NPTS) begin
						push('0, 1'b0, 1'b1, STAT_FULL);
						return;
					end
					id = npoints;
					pt_x[id] = it.x;
					pt_y[id] = it.y;
					pt_lvl[id] = it.oct;
					npoints++;
					cx = rnd((x - ox) * iw);
					cy = rnd((y - oy) * ih);
					if (cx < 0 || cx >= COLS || cy < 0 || cy >= ROWS) begin
						push(10'(id), 1'b1, 1'b1, STAT_OUT);
						return;
					end
					cidx = int'(cx * ROWS + cy);
					if (fill[cidx] >= DEPTH) begin
						push(10'(id), 1'b1, 1'b1, STAT_FULL);
						return;
					end
					bucket[cidx*DEPTH + fill[cidx]] = id;
					fill[cidx]++;
					push(10'(id), 1'b1, 1'b1, STAT_OK);
				end
				MODE_QRY: begin
					c0 = fl((x - ox - r) * iw);
					c1 = -fl(-((x - ox + r) * iw));
					r0 = fl((y - oy - r) * ih);
					r1 = -fl(-((y - oy + r) * ih));
					if (c0 < 0) c0 = 0;
					if (c1 > COLS - 1) c1 = COLS - 1;
					if (r0 < 0) r0 = 0;
					if (r1 > ROWS - 1) r1 = ROWS - 1;
					if (c0 >= COLS || c1 < 0 || r0 >= ROWS || r1 < 0) begin
						push('0, 1'b0, 1'b1, STAT_OK);
						return;
					end
					chk = (it.minl > 0) || (it.maxl >= 0);
					trunc = 0;
					n = 0;
					first = pending_beats.size();
					for (longint ci = c0; ci <= c1 && !trunc; ci++)
						for (longint ri = r0; ri <= r1 && !trunc; ri++) begin
							cidx = int'(ci * ROWS + ri);
							for (int j = 0; j < fill[cidx] && !trunc; j++) begin
								id = bucket[cidx*DEPTH + j];
								if (chk && (pt_lvl[id] < it.minl ||
										(it.maxl >= 0 && $signed({1'b0, pt_lvl[id]}) > it.maxl)))
									continue;
								dx = longint'(pt_x[id]) - x;
								dy = longint'(pt_y[id]) - y;
								if (dx < 0) dx = -dx;
								if (dy < 0) dy = -dy;
								if (dx < r && dy < r) begin
									if (n >= NHITS)
										trunc = 1;
									else begin
										push(10'(id), 1'b1, 1'b0, STAT_OK);
										n++;
									end
								end
							end
						end
					if (n == 0)
						push('0, 1'b0, 1'b1, STAT_OK);
					else begin
						pending_beats[first + n - 1].last = 1;
						if (trunc) pending_beats[first + n - 1].status = STAT_TRUNC;
					end
				end
				default: ;
			endcase
		endfunction

		function void check_beat(kp_beat_t got);
			kp_beat_t e;
			if (pending_beats.size() == 0) begin
				$error("unexpected result beat idx=%0d", got.idx);
				errors++;
				return;
			end
			e = pending_beats.pop_front();
			if (got.idx !== e.idx) begin
				$error("feature_index expected %0d got %0d", e.idx, got.idx);
				errors++;
			end
			if (got.hit !== e.hit) begin
				$error("hit_valid expected %0d got %0d", e.hit, got.hit);
				errors++;
			end
			if (got.last !== e.last) begin
				$error("last expected %0d got %0d", e.last, got.last);
				errors++;
			end
			if (got.status !== e.status) begin
				$error("status expected %0d got %0d", e.status, got.status);
				errors++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        psel, penable, pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	bit          calm;

	kgq_in_if  in_ch();
	kgq_out_if out_ch();

	grid_scoreboard sb;

	keypoint_grid_bucket_and_window_query DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (in_ch),
		.out_ch  (out_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	initial begin
		#400_000_000;
		$display("keypoint_grid_bucket_and_window_query: mismatch");
		$finish;
	end

	// receiver: ready in random bursts, always high once calm
	initial begin
		int n;
		out_ch.ready = 0;
		forever begin
			n = $urandom_range(1, 20);
			repeat (n) begin
				@(negedge clk);
				out_ch.ready = 1;
			end
			if (!calm) begin
				n = $urandom_range(1, 14);
				repeat (n) begin
					@(negedge clk);
					out_ch.ready = calm;
				end
			end
		end
	end

	always @(posedge clk) begin
		kp_beat_t b;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			b.idx = out_ch.feature_index;
			b.hit = out_ch.hit_valid;
			b.last = out_ch.last;
			b.status = kgq_status_t'(out_ch.status);
			sb.check_beat(b);
		end
	end

	task automatic send(kp_item_t it);
		int gap;
		if (!calm && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 14);
			@(negedge clk);
			in_ch.valid = 0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_ch.valid = 1;
		in_ch.mode = it.mode;
		in_ch.pos_x = it.x;
		in_ch.pos_y = it.y;
		in_ch.octave = it.oct;
		in_ch.radius = it.rad;
		in_ch.min_level = it.minl;
		in_ch.max_level = it.maxl;
		do @(posedge clk); while (!in_ch.ready);
		sb.note_item(it);
	endtask

	task automatic drain();
		@(negedge clk);
		in_ch.valid = 0;
		while (sb.pending_beats.size() != 0) @(posedge clk);
		// a no-op item leaves no beat to wait for
		repeat (50) @(posedge clk);
	endtask

	task automatic write_reg(kgq_reg_t r, logic [15:0] v);
		@(negedge clk);
		psel = 1;
		penable = 0;
		pwrite = 1;
		paddr = {r, 2'b00};
		pwdata = {16'h0, v};
		@(negedge clk);
		penable = 1;
		do @(posedge clk); while (!pready);
		sb.set_reg(r, v);
		@(negedge clk);
		psel = 0;
		penable = 0;
	endtask

	task automatic set_grid(logic [15:0] ox, logic [15:0] oy, logic [15:0] iw,
			logic [15:0] ih);
		drain();
		write_reg(REG_ORIGIN_X, ox);
		write_reg(REG_ORIGIN_Y, oy);
		write_reg(REG_INV_W, iw);
		write_reg(REG_INV_H, ih);
	endtask

	function automatic kp_item_t mk(kgq_mode_t m, int x, int y, int o, int r, int mn,
			int mx);
		kp_item_t it;
		it.mode = m;
		it.x = 16'(x);
		it.y = 16'(y);
		it.oct = 3'(o);
		it.rad = 15'(r);
		it.minl = 3'(mn);
		it.maxl = 4'(mx);
		return it;
	endfunction

	function automatic logic signed [15:0] sat16(longint v);
		if (v > 32767) return 16'sh7fff;
		if (v < -32768) return 16'sh8000;
		return 16'(v);
	endfunction

	// a coordinate that mostly lands inside the grid span on that axis
	function automatic logic signed [15:0] grid_coord(logic signed [15:0] org,
			logic [15:0] inv, int cells);
		longint span;
		if ($urandom_range(0, 4) == 0) return 16'($urandom);
		span = (inv == 0) ? 4000 : (longint'(cells) << 20) / inv;
		if (span > 65535) span = 65535;
		return sat16(longint'(org) + $urandom_range(0, span + 64) - 32);
	endfunction

	function automatic kp_item_t rand_item();
		kp_item_t it;
		int p, k;
		it = mk(MODE_INS, 0, 0, $urandom_range(0, 7), 0, 0, -1);
		it.rad = $urandom_range(0, 3) == 0 ? 15'($urandom) : 15'($urandom_range(0, 900));
		it.minl = $urandom_range(0, 1) ? 3'd0 : 3'($urandom_range(0, 7));
		it.maxl = $urandom_range(0, 1) ? -4'sd1 : 4'($urandom_range(0, 15));
		p = $urandom_range(0, 99);
		if (p < 3) it.mode = MODE_CLR;
		else if (p < 6) it.mode = MODE_NOP;
		else if (p < 58) it.mode = MODE_INS;
		else it.mode = MODE_QRY;
		if (it.mode == MODE_QRY && sb.npoints > 0 && $urandom_range(0, 2) != 0) begin
			k = $urandom_range(0, sb.npoints - 1);
			it.x = sat16(longint'(sb.pt_x[k]) + $urandom_range(0, 64) - 32);
			it.y = sat16(longint'(sb.pt_y[k]) + $urandom_range(0, 64) - 32);
		end else begin
			it.x = grid_coord(sb.org_x, sb.inv_w, COLS);
			it.y = grid_coord(sb.org_y, sb.inv_h, ROWS);
		end
		return it;
	endfunction

	task automatic random_items(int n);
		repeat (n) send(rand_item());
	endtask

	initial begin
		sb = new();
		calm = 0;
		arst_n = 0;
		psel = 0;
		penable = 0;
		pwrite = 0;
		paddr = 0;
		pwdata = 0;
		in_ch.valid = 0;
		in_ch.mode = MODE_CLR;
		in_ch.pos_x = 0;
		in_ch.pos_y = 0;
		in_ch.octave = 0;
		in_ch.radius = 0;
		in_ch.min_level = 0;
		in_ch.max_level = 0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// directed part at the reset settings (160 px cells)
		send(mk(MODE_QRY, 100, 100, 0, 500, 0, -1));          // empty table
		send(mk(MODE_INS, 0, 0, 0, 0, 0, -1));
		send(mk(MODE_INS, 20, 30, 7, 0, 0, -1));
		send(mk(MODE_INS, 79, 79, 3, 0, 0, -1));
		send(mk(MODE_INS, 32767, 32767, 5, 0, 0, -1));        // outside
		send(mk(MODE_INS, -32768, -32768, 1, 0, 0, -1));      // outside
		send(mk(MODE_INS, 10000, 7000, 2, 0, 0, -1));
		send(mk(MODE_NOP, 1, 2, 3, 4, 5, 6));
		send(mk(MODE_QRY, 20, 30, 0, 0, 0, -1));              // zero radius
		send(mk(MODE_QRY, 20, 30, 0, 100, 0, -1));
		send(mk(MODE_QRY, 20, 30, 0, 32767, 0, -1));          // whole grid
		send(mk(MODE_QRY, 20, 30, 0, 32767, 7, 7));
		send(mk(MODE_QRY, 20, 30, 0, 32767, 0, 3));
		send(mk(MODE_QRY, 20, 30, 0, 32767, 3, -1));
		send(mk(MODE_QRY, 20, 30, 0, 32767, 5, 1));           // empty level range
		send(mk(MODE_QRY, 20, 30, 0, 32767, 0, -8));
		send(mk(MODE_QRY, -32768, -32768, 0, 50, 0, -1));     // window off grid
		send(mk(MODE_QRY, 32767, 32767, 0, 50, 0, -1));
		send(mk(MODE_CLR, 0, 0, 0, 0, 0, -1));
		send(mk(MODE_QRY, 20, 30, 0, 32767, 0, -1));
		random_items(60);

		// the sender waits for every outstanding beat before moving on
		set_grid(16'h8000, 16'h7fff, 16'hffff, 16'hffff);
		random_items(30);
		set_grid(16'hffc0, 16'hffc0, 16'hffff, 16'h4000);
		random_items(40);
		set_grid(16'h0000, 16'h0000, 16'h0000, 16'h0000);     // everything in cell 0
		random_items(30);
		set_grid(16'h7fff, 16'h8000, 16'h0100, 16'h0800);
		random_items(30);
		set_grid(16'($urandom_range(0, 2000)), 16'($urandom_range(0, 2000)),
			16'($urandom_range(1000, 20000)), 16'($urandom_range(1000, 20000)));
		random_items(60);

		// closing phase without idling: clustered inserts fill buckets
		set_grid(16'h0000, 16'h0000, 16'd6554, 16'd6554);
		calm = 1;
		send(mk(MODE_CLR, 0, 0, 0, 0, 0, -1));
		// four cells share these, so their buckets overflow
		repeat (70)
			send(mk(MODE_INS, $urandom_range(0, 160), $urandom_range(0, 160),
				$urandom_range(0, 7), 0, 0, -1));
		repeat (30)
			send(mk(MODE_INS, $urandom_range(0, 480), $urandom_range(0, 480),
				$urandom_range(0, 7), 0, 0, -1));
		send(mk(MODE_QRY, 240, 240, 0, 900, 0, -1));          // more hits than the limit
		send(mk(MODE_QRY, 240, 240, 0, 900, 2, 4));
		send(mk(MODE_QRY, 80, 80, 0, 200, 0, -1));
		random_items(10);

		drain();
		if (sb.errors == 0)
			$display("keypoint_grid_bucket_and_window_query: match");
		else
			$display("keypoint_grid_bucket_and_window_query: mismatch");
		$finish;
	end

endmodule
